// File: rtl/sha_pkg.sv
// sha_pkg: shared types, constants and round functions for the sha-256 stream hasher
// no dependencies; used by every module under rtl
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_req_t;

  // one word-level request from the front to the back
  typedef enum logic [1:0] {
    CMD_WORD  = 2'd0,  // message word, block not yet full
    CMD_BLOCK = 2'd1,  // message word that closes a block
    CMD_FINAL = 2'd2   // word that closes the last block, then emit digest
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] word;
  } word_req_t;

  typedef enum logic [1:0] {
    FS_IDLE = 2'd0,
    FS_PAD  = 2'd1
  } front_state_e;

  typedef enum logic [1:0] {
    BS_LOAD  = 2'd0,
    BS_ROUND = 2'd1,
    BS_ADD   = 2'd2,
    BS_EMIT  = 2'd3
  } back_state_e;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// File: rtl/sha_front.sv
// sha_front: packs message bytes into 32-bit words, appends padding and length
// depends on sha_pkg
module sha_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::in_req_t   in_data_i,
  output logic               wq_valid_o,
  input  logic               wq_ready_i,
  output sha_pkg::word_req_t wq_data_o
);

  sha_pkg::front_state_e state_q, state_d;
  logic [60:0] count_q, count_d;
  logic [23:0] part_q, part_d;
  logic [63:0] bits_q, bits_d;
  logic [3:0]  wpos_q, wpos_d;   // word slot in the padding pass
  logic        tail_q, tail_d;   // next pass word carries the tail bytes and pad
  logic        spill_q, spill_d; // no room for the length in the current block

  logic [1:0]  bpos;
  logic [3:0]  wslot;
  logic        have_byte;
  logic        word_done;
  logic [31:0] full_word;
  logic [31:0] tail_word;
  logic [60:0] count_inc;
  logic [60:0] msg_len;

  assign bpos      = count_q[1:0];
  assign wslot     = count_q[5:2];
  assign count_inc = count_q + 61'd1;
  assign have_byte = in_data_i.byte_valid;
  assign word_done = have_byte && (bpos == 2'd3);
  assign full_word = {part_q, in_data_i.data_byte};
  assign msg_len   = have_byte ? count_inc : count_q;

  // tail bytes of the message followed by the pad byte
  always_comb begin
    case (count_q[1:0])
      2'd0:    tail_word = {sha_pkg::PadByte, 24'h0};
      2'd1:    tail_word = {part_q[23:16], sha_pkg::PadByte, 16'h0};
      2'd2:    tail_word = {part_q[23:8], sha_pkg::PadByte, 8'h0};
      default: tail_word = {part_q, sha_pkg::PadByte};
    endcase
  end

  // front control: byte packing, then a word-by-word padding pass
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    part_d     = part_q;
    bits_d     = bits_q;
    wpos_d     = wpos_q;
    tail_d     = tail_q;
    spill_d    = spill_q;
    in_ready_o = 1'b0;
    wq_valid_o = 1'b0;
    wq_data_o  = '{cmd: sha_pkg::CMD_WORD, word: full_word};
    case (state_q)
      sha_pkg::FS_IDLE: begin
        // a byte that completes a word needs a queue slot
        in_ready_o    = word_done ? wq_ready_i : 1'b1;
        wq_valid_o    = in_valid_i && word_done;
        wq_data_o.cmd = (wslot == 4'hf) ? sha_pkg::CMD_BLOCK : sha_pkg::CMD_WORD;
        if (in_valid_i && in_ready_o) begin
          if (have_byte) begin
            count_d = count_inc;
            case (bpos)
              2'd0: part_d = {in_data_i.data_byte, 16'h0};
              2'd1: part_d = {part_q[23:16], in_data_i.data_byte, 8'h0};
              2'd2: part_d = {part_q[23:8], in_data_i.data_byte};
              default: part_d = part_q;
            endcase
          end
          // end mark: the pass starts at the word that takes the pad byte
          if (in_data_i.end_of_message) begin
            state_d = sha_pkg::FS_PAD;
            count_d = msg_len;
            bits_d  = {msg_len, 3'b000};
            wpos_d  = msg_len[5:2];
            tail_d  = 1'b1;
            spill_d = (msg_len[5:2] >= 4'd14);
          end
        end
      end
      sha_pkg::FS_PAD: begin
        // first word of the pass holds the tail bytes and pad, later ones zero
        wq_valid_o     = 1'b1;
        wq_data_o.word = tail_q ? tail_word : 32'h0;
        wq_data_o.cmd  = (wpos_q == 4'hf) ? sha_pkg::CMD_BLOCK : sha_pkg::CMD_WORD;
        // length words go into slots 14 and 15 of the final block
        if (!spill_q && wpos_q == 4'd14) wq_data_o.word = bits_q[63:32];
        if (!spill_q && wpos_q == 4'hf) begin
          wq_data_o.word = bits_q[31:0];
          wq_data_o.cmd  = sha_pkg::CMD_FINAL;
        end
        if (wq_ready_i) begin
          tail_d = 1'b0;
          wpos_d = wpos_q + 4'd1;
          if (wpos_q == 4'hf) begin
            // spilled pad: one more block of zeros and length follows
            spill_d = 1'b0;
            if (!spill_q) begin
              state_d = sha_pkg::FS_IDLE;
              count_d = 61'h0;
            end
          end
        end
      end
      default: state_d = sha_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::FS_IDLE;
      count_q <= 61'h0;
      wpos_q  <= 4'h0;
      bits_q  <= 64'h0;
      tail_q  <= 1'b0;
      spill_q <= 1'b0;
      part_q  <= 24'h0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wpos_q  <= wpos_d;
      bits_q  <= bits_d;
      tail_q  <= tail_d;
      spill_q <= spill_d;
      part_q  <= part_d;
    end
  end

endmodule

// File: rtl/sha_queue.sv
// sha_queue: short word request queue between the front and the back
// depends on sha_pkg
module sha_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  sha_pkg::word_req_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output sha_pkg::word_req_t pop_data_o
);

  sha_pkg::word_req_t mem_q [sha_pkg::QueueDepth];
  logic [sha_pkg::QueueAw-1:0] wr_q, rd_q;
  logic [sha_pkg::QueueAw:0]   fill_q;
  logic push, pop;

  assign push_ready_o = (fill_q != (sha_pkg::QueueAw+1)'(sha_pkg::QueueDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      fill_q <= fill_q + (sha_pkg::QueueAw+1)'(push) - (sha_pkg::QueueAw+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// File: rtl/sha_back.sv
// sha_back: message schedule, one round per cycle, chaining update and digest output
// depends on sha_pkg
module sha_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wq_valid_i,
  output logic               wq_ready_o,
  input  sha_pkg::word_req_t wq_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::out_req_t  out_data_o
);

  sha_pkg::back_state_e state_q, state_d;
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [5:0]  rnd_q, rnd_d;
  logic        fin_q, fin_d;
  logic [2:0]  oidx_q, oidx_d;

  logic [31:0] w_cur, w_new, t1, t2, ch, maj;
  logic        load, do_round, do_add, emit;

  // schedule: the window shifts one word each round
  assign w_cur = w_q[0];
  assign w_new = sha_pkg::sig1(w_q[14]) + w_q[9] + sha_pkg::sig0(w_q[1]) + w_q[0];
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + sha_pkg::bsig1(v_q[4]) + ch + sha_pkg::RoundK[rnd_q] + w_cur;
  assign t2    = sha_pkg::bsig0(v_q[0]) + maj;

  assign out_data_o = '{digest_word: h_q[oidx_q], word_number: oidx_q,
                        last_word: (oidx_q == 3'd7)};

  // control
  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    fin_d      = fin_q;
    oidx_d     = oidx_q;
    wq_ready_o = 1'b0;
    out_valid_o = 1'b0;
    load = 1'b0; do_round = 1'b0; do_add = 1'b0; emit = 1'b0;
    case (state_q)
      sha_pkg::BS_LOAD: begin
        wq_ready_o = 1'b1;
        if (wq_valid_i) begin
          load   = 1'b1;
          if (wq_data_i.cmd != sha_pkg::CMD_WORD) begin
            state_d = sha_pkg::BS_ROUND;
            rnd_d   = 6'd0;
            fin_d   = (wq_data_i.cmd == sha_pkg::CMD_FINAL);
          end
        end
      end
      sha_pkg::BS_ROUND: begin
        do_round = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = sha_pkg::BS_ADD;
      end
      sha_pkg::BS_ADD: begin
        do_add = 1'b1;
        oidx_d = 3'd0;
        state_d = fin_q ? sha_pkg::BS_EMIT : sha_pkg::BS_LOAD;
      end
      sha_pkg::BS_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            emit = 1'b1;
            state_d = sha_pkg::BS_LOAD;
          end
        end
      end
      default: state_d = sha_pkg::BS_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::BS_LOAD;
      rnd_q   <= 6'd0;
      fin_q   <= 1'b0;
      oidx_q  <= 3'd0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitH[i];
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      fin_q   <= fin_d;
      oidx_q  <= oidx_d;
      if (do_add) for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      if (emit)   for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitH[i];
    end
  end

  // datapath: word window and working variables
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wq_data_i.word;
      if (wq_data_i.cmd != sha_pkg::CMD_WORD) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
    end
    if (do_round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

endmodule

// File: rtl/sha256_stream_hasher.sv
// sha256_stream_hasher: top level, front packer, word queue and compression back end
// depends on sha_pkg, sha_front, sha_queue, sha_back

// A byte request is taken while in_ready_o is high; every fourth byte pushes a
// word into a four-entry queue. The back end loads 16 words per block and then
// spends 64 rounds and one add on it in the single round unit; meanwhile the
// queue and the partial word absorb only 19 bytes, so a steady byte stream
// stalls. An end mark holds input off while the front pushes a padding pass of
// one or two blocks, one word per cycle while the queue has room, then eight
// digest words leave, one per accepted result.
module sha256_stream_hasher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sha_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sha_pkg::out_req_t out_data_o
);

  logic fq_valid, fq_ready, bq_valid, bq_ready;
  sha_pkg::word_req_t fq_data, bq_data;

  sha_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .wq_valid_o(fq_valid), .wq_ready_i(fq_ready), .wq_data_o(fq_data)
  );

  sha_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(fq_valid), .push_ready_o(fq_ready), .push_data_i(fq_data),
    .pop_valid_o(bq_valid), .pop_ready_i(bq_ready), .pop_data_o(bq_data)
  );

  sha_back u_back (
    .clk_i, .rst_ni,
    .wq_valid_i(bq_valid), .wq_ready_o(bq_ready), .wq_data_i(bq_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

// File: rtl/sha_checker.sv
// sha_checker: port-level checks on the hasher
// depends on sha_pkg; bound to sha256_stream_hasher
module sha_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input sha_pkg::out_req_t out_data_o
);

  // handshake lines stay known out of reset
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_valid_i, in_ready_o, out_valid_o, out_ready_i}))
    else $error("unknown handshake");

  // last_word marks word seven only
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_number == 3'd7)))
    else $error("last_word mismatch");

  // word numbers step by one within a digest
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last_word) |=>
      (out_data_o.word_number == $past(out_data_o.word_number) + 3'd1))
    else $error("word_number skipped");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped while stalled");

endmodule

bind sha256_stream_hasher sha_checker u_checker (.*);
